>>> design/pfp_pkg.sv
// Shared types and constants of the position frame parser.
`default_nettype none

package pfp_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hFE;
  localparam logic [7:0] TAIL_BYTE   = 8'hEF;
  localparam int         STORE_LEN   = 6;
  localparam int         STORE_IDX_W = $clog2(STORE_LEN);
  localparam int         FIFO_DEPTH  = 2;
  localparam int         CNT_W       = $clog2(FIFO_DEPTH + 1);

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_SUM     = 3'd3,
    PH_TAIL    = 3'd4
  } phase_e;

  // Result item, pos_x in the lowest bits.
  typedef struct packed {
    logic [15:0] pos_z;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } res_t;

  // Parser to output queue.
  typedef struct packed {
    logic valid;
    res_t data;
  } res_push_t;

endpackage

`default_nettype wire

>>> design/pfp_parser.sv
// Frame state machine, payload sum and six-byte payload store.
`default_nettype none

module pfp_parser
  import pfp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire byte_t     byte_i,
  output res_push_t      push_o
);

  phase_e phase_q, phase_d;
  byte_t  len_q, len_d;
  byte_t  sum_q, sum_d;
  byte_t  idx_q, idx_d;
  byte_t  store_q [STORE_LEN];
  logic   store_we;
  logic   frame_ok;

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    sum_d    = sum_q;
    idx_d    = idx_q;
    store_we = 1'b0;
    case (phase_q)
      PH_IDLE: begin
        if (byte_i == HDR_BYTE) begin
          phase_d = PH_LEN;
          len_d   = 8'd0;
        end
      end
      PH_LEN: begin
        len_d   = byte_i;
        sum_d   = 8'd0;
        idx_d   = 8'd0;
        phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (({1'b0, idx_q} + 9'd1) < {1'b0, len_q}) begin
          store_we = (idx_q < 8'(STORE_LEN));
          idx_d    = idx_q + 8'd1;
          sum_d    = sum_q + byte_i;
        end else begin
          // this beat is the ignored byte
          phase_d = PH_SUM;
        end
      end
      PH_SUM: begin
        phase_d = (byte_i == sum_q) ? PH_TAIL : PH_IDLE;
      end
      PH_TAIL: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    frame_ok          = (phase_q == PH_TAIL) && (byte_i == TAIL_BYTE);
    push_o.valid      = fire_i && frame_ok;
    push_o.data.pos_x = {store_q[1], store_q[0]};
    push_o.data.pos_y = {store_q[3], store_q[2]};
    push_o.data.pos_z = {store_q[5], store_q[4]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      len_q   <= 8'd0;
      sum_q   <= 8'd0;
      idx_q   <= 8'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_LEN; i++) begin
        store_q[i] <= 8'd0;
      end
    end else if (fire_i && store_we) begin
      store_q[idx_q[STORE_IDX_W-1:0]] <= byte_i;
    end
  end

`ifndef ASSERT_OFF
  a_push_from_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |=> phase_q == PH_IDLE)
    else $error("result pushed without returning to idle");
  a_len_to_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && phase_q == PH_LEN) |=> (phase_q == PH_PAYLOAD && idx_q == 8'd0))
    else $error("length beat did not start the payload");
`endif

endmodule

`default_nettype wire

>>> design/pfp_out_fifo.sv
// Two-entry result queue that decouples the parser from the output stall.
`default_nettype none

module pfp_out_fifo
  import pfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire res_push_t   push_i,
  output logic             full_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output res_t             data_o
);

  res_t             mem_q [FIFO_DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i.valid, pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.valid) wr_ptr_q <= ~wr_ptr_q;
      if (pop)          rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("result pushed into a full queue");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CNT_W'(1)) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> design/position_frame_parser_top.sv
// Top level of the position frame parser: input register, parser, result queue.
//
// Usage:
//   Slave stream s_axis_* carries one received byte per beat in tdata.
//   Frames are 0xFE, a length L, L-1 payload bytes, one ignored byte, the
//   8-bit wrapping payload sum and 0xEF. Bytes outside a frame are dropped.
//   Master stream m_axis_* carries one 48-bit result per good frame:
//   pos_x, pos_y, pos_z, each little endian from payload bytes 0..5.
// Throughput: one byte per clock, sustained while the result queue has room,
//   whatever the frame contents; the parser updates its state once per byte.
// Result path: the input register takes the tail byte of a frame, the
//   parser checks it there and, once the queue has room, its result is
//   written into the result queue, whose head drives m_axis.
// Stall: a two-entry result queue holds results while the receiver is
//   stalled; input keeps flowing until the queue is full and a byte that
//   is waiting in the input register is held there.
// Reset: asynchronous, active low; the parser returns to idle, the length,
//   sum, count and payload store clear to zero and both streams go empty.
`default_nettype none

module position_frame_parser_top
  import pfp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o    // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z
);

  logic      in_valid_q;
  byte_t     in_byte_q;
  logic      fire;
  logic      q_full;
  res_push_t push;
  res_t      out_data;

  // Parse the held byte whenever the queue has room for a possible result.
  assign fire            = in_valid_q && !q_full;
  assign s_axis_tready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  pfp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .push_o (push)
  );

  pfp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_data)
  );

  assign m_axis_tdata_o = out_data;

endmodule

`default_nettype wire
